/* src/gbc_pkg.sv */
// Shared types, constants and round function for the GOST 28147-89 ECB cipher.
// Used by every module of the block; depends on nothing else.
package gbc_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned KEY_WORDS = 8;
   localparam int unsigned KIDX_W    = $clog2(KEY_WORDS);
   localparam int unsigned ROUNDS    = 32;
   localparam int unsigned ROT_BITS  = 11;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_type;

   // One block in flight: the two halves, the direction and the last-block flag.
   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   n1;
      logic [WORD_W-1:0]   n2;
      logic                last;
   } item_type;

   // SBOX[n] is applied to nibble n, nibble 0 being the least significant.
   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
        4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
      '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
        4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
      '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
        4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
      '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
        4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
      '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
        4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
      '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
        4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7}
   };

   // Eight parallel S-box lookups followed by a rotate left.
   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] s;
      s = '0;
      for (int n = 0; n < 8; n++) begin
         s[4*n +: 4] = SBOX[n][v[4*n +: 4]];
      end
      return {s[WORD_W-ROT_BITS-1:0], s[WORD_W-1:WORD_W-ROT_BITS]};
   endfunction

endpackage

/* src/gbc_round.sv */
// One registered Feistel round of the cipher pipeline.
// Depends on gbc_pkg for the item type and the round function.
module gbc_round #(
   parameter int unsigned ROUND = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  gbc_pkg::item_type   in_item,
   input  gbc_pkg::key_set_type key_words,
   output logic                out_vld,
   output gbc_pkg::item_type   out_item
);
   import gbc_pkg::*;

   localparam int unsigned POS     = ROUND % KEY_WORDS;
   localparam int unsigned ENC_IDX = (ROUND < 24) ? POS : (KEY_WORDS - 1 - POS);
   localparam int unsigned DEC_IDX = (ROUND < 8)  ? POS : (KEY_WORDS - 1 - POS);
   localparam logic [KIDX_W-1:0] ENC_K = KIDX_W'(ENC_IDX);
   localparam logic [KIDX_W-1:0] DEC_K = KIDX_W'(DEC_IDX);

   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] f;
   item_type          item_in;
   logic              vld_ff;
   item_type          item_ff;

   always_comb begin
      key = (in_item.op == OP_DECRYPT) ? key_words[DEC_K] : key_words[ENC_K];
      item_in = in_item;
      // Even rounds mix N1 into N2, odd rounds N2 into N1.
      if ((ROUND % 2) == 0) begin
         f = round_fn(in_item.n1 + key);
         item_in.n2 = in_item.n2 ^ f;
      end else begin
         f = round_fn(in_item.n2 + key);
         item_in.n1 = in_item.n1 ^ f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

/* src/gbc_out_skid.sv */
// Output register with a skid entry, so the pipeline stalls only on a registered flag.
// Depends on gbc_pkg for the item type.
module gbc_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_vld,
   input  gbc_pkg::item_type push_item,
   output logic              pipe_en,
   output logic              out_vld,
   input  logic              out_rdy,
   output gbc_pkg::item_type out_item
);
   import gbc_pkg::*;

   logic     out_vld_ff;
   item_type out_item_ff;
   logic     skid_vld_ff;
   item_type skid_item_ff;
   logic     push;
   logic     pop;

   // The pipeline moves only while the skid entry is free to catch its last item.
   assign pipe_en = !skid_vld_ff;
   assign push    = pipe_en && push_vld;
   assign pop     = out_vld_ff && out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || pop) begin
            if (skid_vld_ff) begin
               out_vld_ff  <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= push;
            end
         end else if (push) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || pop) begin
         out_item_ff <= skid_vld_ff ? skid_item_ff : push_item;
      end else if (push) begin
         skid_item_ff <= push_item;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_item = out_item_ff;

endmodule

/* src/gost_block_cipher_ecb.sv */
// Top level of the GOST 28147-89 ECB cipher: key registers, round pipeline, output buffer.
// Depends on gbc_pkg, gbc_round and gbc_out_skid.
//
// The block takes one 64-bit block per clock while req_tready is high and
// returns it encrypted or decrypted in order, through 32 round stages and
// the output register. Each of the 32 rounds
// has its own register stage (key add, S-boxes, rotate, XOR), and an output
// register with one skid entry follows, so a stalled result side holds the
// whole pipeline only once that entry is filled. tuser picks the direction
// (0 encrypt, 1 decrypt) and tlast passes through with the block. The key is
// read live by every stage: write it only while no item is in flight.
module gost_block_cipher_ecb (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_we,
   input  logic [gbc_pkg::KIDX_W-1:0]    csr_index,
   input  logic [gbc_pkg::WORD_W-1:0]    csr_wdata,
   // input items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,  // block_first_half, block_second_half
   input  logic                          req_tuser,  // opcode
   input  logic                          req_tlast,  // last_block
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,  // out_first_half, out_second_half
   output logic                          rsp_tlast   // out_last_block
);
   import gbc_pkg::*;

   key_set_type key_ff;
   logic        pipe_en;
   logic        vld [ROUNDS+1];
   item_type    item [ROUNDS+1];
   item_type    rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   assign req_tready = pipe_en;
   assign vld[0]     = req_tvalid;

   always_comb begin
      item[0].op   = op_type'(req_tuser);
      item[0].n1   = req_tdata[WORD_W-1:0];
      item[0].n2   = req_tdata[2*WORD_W-1:WORD_W];
      item[0].last = req_tlast;
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      gbc_round #(.ROUND(r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_vld    (vld[r]),
         .in_item   (item[r]),
         .key_words (key_ff),
         .out_vld   (vld[r+1]),
         .out_item  (item[r+1])
      );
   end

   gbc_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (vld[ROUNDS]),
      .push_item (item[ROUNDS]),
      .pipe_en   (pipe_en),
      .out_vld   (rsp_tvalid),
      .out_rdy   (rsp_tready),
      .out_item  (rsp_item)
   );

   // The halves leave swapped.
   assign rsp_tdata = {rsp_item.n1, rsp_item.n2};
   assign rsp_tlast = rsp_item.last;

endmodule
